[src/pts_pkg.sv]
// Shared types for the point to segment distance pipeline.
package pts_pkg;

  // Per-stage pipeline control handed to the arithmetic units.
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  // Which point the foot is taken from.
  typedef enum logic [2:0] {
    SEL_A    = 3'b001,
    SEL_B    = 3'b010,
    SEL_PROJ = 3'b100
  } foot_sel_e;

endpackage

[src/pts_delay.sv]
// Enabled delay line that carries sideband data alongside an arithmetic unit.
module pts_delay #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
      for (int i = 1; i < Depth; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign data_o = tap_q[Depth-1];

endmodule

[src/pts_div.sv]
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
module pts_div import pts_pkg::*; #(
  parameter int W = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pipe_ctl_t     ctl_i,
  input  logic [3*W:0]  num_i,
  input  logic [2*W:0]  den_i,
  output logic          vld_o,
  output logic [W-1:0]  quo_o
);

  localparam int RemW = 2 * W + 1;

  logic            vld [W+1];
  logic [RemW-1:0] rem [W+1];
  logic [W-1:0]    low [W+1];
  logic [RemW-1:0] den [W+1];
  logic [W-1:0]    quo [W+1];

  // The quotient is known to fit in W bits, so the upper numerator bits
  // already lie below the divisor and can seed the remainder.
  assign vld[0] = ctl_i.vld;
  assign rem[0] = num_i[3*W:W];
  assign low[0] = num_i[W-1:0];
  assign den[0] = den_i;
  assign quo[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [RemW:0]   trial;
    logic            fit;
    logic [RemW-1:0] rem_d;
    logic            vld_q;
    logic [RemW-1:0] rem_q;
    logic [W-1:0]    low_q;
    logic [RemW-1:0] den_q;
    logic [W-1:0]    quo_q;

    assign trial = {rem[k], low[k][W-1]};
    assign fit   = trial >= {1'b0, den[k]};
    assign rem_d = fit ? RemW'(trial - {1'b0, den[k]}) : trial[RemW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q <= rem_d;
        low_q <= {low[k][W-2:0], 1'b0};
        den_q <= den[k];
        quo_q <= {quo[k][W-2:0], fit};
      end
    end

    assign vld[k+1] = vld_q;
    assign rem[k+1] = rem_q;
    assign low[k+1] = low_q;
    assign den[k+1] = den_q;
    assign quo[k+1] = quo_q;
  end

  logic         vld_q;
  logic [W-1:0] quo_q;
  logic         round_up;

  // Round half up: bump when twice the remainder reaches the divisor.
  assign round_up = {rem[W], 1'b0} >= {1'b0, den[W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q <= vld[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      quo_q <= quo[W] + W'(round_up);
    end
  end

  assign vld_o = vld_q;
  assign quo_o = quo_q;

endmodule

[src/pts_sqrt.sv]
// Pipelined integer square root, one root bit per stage, floored.
module pts_sqrt import pts_pkg::*; #(
  parameter int W = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pipe_ctl_t      ctl_i,
  input  logic [2*W+2:0] rad_i,
  output logic           vld_o,
  output logic [W:0]     root_o
);

  localparam int RootW = W + 2;
  localparam int RadW  = 2 * RootW;

  logic             vld  [RootW+1];
  logic [RootW:0]   rem  [RootW+1];
  logic [RootW-1:0] root [RootW+1];
  logic [RadW-1:0]  rad  [RootW+1];

  assign vld[0]  = ctl_i.vld;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = {1'b0, rad_i};

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RootW+2:0] cand;
    logic [RootW+2:0] trial;
    logic             fit;
    logic             vld_q;
    logic [RootW:0]   rem_q;
    logic [RootW-1:0] root_q;
    logic [RadW-1:0]  rad_q;

    // Bring down the next pair of radicand bits and try appending a one.
    assign cand  = {rem[k], rad[k][RadW-1:RadW-2]};
    assign trial = {1'b0, root[k], 2'b01};
    assign fit   = cand >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q  <= fit ? (RootW+1)'(cand - trial) : cand[RootW:0];
        root_q <= {root[k][RootW-2:0], fit};
        rad_q  <= {rad[k][RadW-3:0], 2'b00};
      end
    end

    assign vld[k+1]  = vld_q;
    assign rem[k+1]  = rem_q;
    assign root[k+1] = root_q;
    assign rad[k+1]  = rad_q;
  end

  assign vld_o  = vld[RootW];
  assign root_o = root[RootW][W:0];

endmodule

[src/point_to_segment_distance_top.sv]
// Top level of the point to segment distance pipeline.
// One query (segment A to B and point C, signed Q15.8) is taken in every
// cycle in which the pipe advances, and one result leaves per query in
// order. A query passes through the registered stages for differences,
// products and clamping decision, the bit-per-stage divider for the
// projection, the stages for the foot and the squared distance, and the
// bit-per-stage square root, whose last stage is the output register.
// The whole pipe advances whenever the output register is empty or its
// beat is taken.
module point_to_segment_distance_top import pts_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] foot_x_o,
  output logic signed [COORD_WIDTH-1:0] foot_y_o,
  output logic        [COORD_WIDTH:0]   distance_o,
  output logic                          interior_foot_o
);

  localparam int W = COORD_WIDTH;

  typedef struct packed {
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic signed [W-1:0] bx;
    logic signed [W-1:0] by;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic                neg_x;
    logic                neg_y;
    foot_sel_e           sel;
  } div_side_t;

  typedef struct packed {
    logic [W-1:0] fx;
    logic [W-1:0] fy;
    logic         interior;
  } sqrt_side_t;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: differences.
  logic                s1_vld_q;
  logic signed [W-1:0] s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q, s1_cx_q, s1_cy_q;
  logic signed [W:0]   s1_abx_q, s1_aby_q, s1_acx_q, s1_acy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ax_q  <= seg_start_x_i;
      s1_ay_q  <= seg_start_y_i;
      s1_bx_q  <= seg_end_x_i;
      s1_by_q  <= seg_end_y_i;
      s1_cx_q  <= point_x_i;
      s1_cy_q  <= point_y_i;
      s1_abx_q <= {seg_end_x_i[W-1], seg_end_x_i} - {seg_start_x_i[W-1], seg_start_x_i};
      s1_aby_q <= {seg_end_y_i[W-1], seg_end_y_i} - {seg_start_y_i[W-1], seg_start_y_i};
      s1_acx_q <= {point_x_i[W-1], point_x_i} - {seg_start_x_i[W-1], seg_start_x_i};
      s1_acy_q <= {point_y_i[W-1], point_y_i} - {seg_start_y_i[W-1], seg_start_y_i};
    end
  end

  // Stage 2: products for the dot product and squared length.
  logic                  s2_vld_q;
  logic signed [W-1:0]   s2_ax_q, s2_ay_q, s2_bx_q, s2_by_q, s2_cx_q, s2_cy_q;
  logic signed [W:0]     s2_abx_q, s2_aby_q;
  logic signed [2*W+1:0] s2_tx_q, s2_ty_q, s2_dx_q, s2_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ax_q  <= s1_ax_q;
      s2_ay_q  <= s1_ay_q;
      s2_bx_q  <= s1_bx_q;
      s2_by_q  <= s1_by_q;
      s2_cx_q  <= s1_cx_q;
      s2_cy_q  <= s1_cy_q;
      s2_abx_q <= s1_abx_q;
      s2_aby_q <= s1_aby_q;
      s2_tx_q  <= s1_abx_q * s1_acx_q;
      s2_ty_q  <= s1_aby_q * s1_acy_q;
      s2_dx_q  <= s1_abx_q * s1_abx_q;
      s2_dy_q  <= s1_aby_q * s1_aby_q;
    end
  end

  // Stage 3: t and d, plus the segment direction magnitudes.
  logic                  s3_vld_q;
  logic signed [W-1:0]   s3_ax_q, s3_ay_q, s3_bx_q, s3_by_q, s3_cx_q, s3_cy_q;
  logic signed [2*W+2:0] s3_t_q;
  logic [2*W:0]          s3_d_q;
  logic [W-1:0]          s3_magx_q, s3_magy_q;
  logic                  s3_negx_q, s3_negy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_ax_q   <= s2_ax_q;
      s3_ay_q   <= s2_ay_q;
      s3_bx_q   <= s2_bx_q;
      s3_by_q   <= s2_by_q;
      s3_cx_q   <= s2_cx_q;
      s3_cy_q   <= s2_cy_q;
      s3_t_q    <= {s2_tx_q[2*W+1], s2_tx_q} + {s2_ty_q[2*W+1], s2_ty_q};
      s3_d_q    <= s2_dx_q[2*W:0] + s2_dy_q[2*W:0];
      s3_magx_q <= s2_abx_q[W] ? W'(-s2_abx_q) : s2_abx_q[W-1:0];
      s3_magy_q <= s2_aby_q[W] ? W'(-s2_aby_q) : s2_aby_q[W-1:0];
      s3_negx_q <= s2_abx_q[W];
      s3_negy_q <= s2_aby_q[W];
    end
  end

  // Stage 4: clamping decision and partial products of |AB| * t.
  foot_sel_e    s3_sel;
  logic [2*W:0] s3_tu;

  assign s3_tu = s3_t_q[2*W:0];

  always_comb begin
    if (s3_t_q[2*W+2] || s3_d_q == '0) begin
      s3_sel = SEL_A;
    end else if (s3_t_q[2*W+1:0] > {1'b0, s3_d_q}) begin
      s3_sel = SEL_B;
    end else begin
      s3_sel = SEL_PROJ;
    end
  end

  logic                s4_vld_q;
  logic signed [W-1:0] s4_ax_q, s4_ay_q, s4_bx_q, s4_by_q, s4_cx_q, s4_cy_q;
  logic [2*W:0]        s4_d_q;
  logic                s4_negx_q, s4_negy_q;
  foot_sel_e           s4_sel_q;
  logic [2*W-1:0]      s4_plx_q, s4_ply_q;
  logic [2*W:0]        s4_phx_q, s4_phy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_ax_q   <= s3_ax_q;
      s4_ay_q   <= s3_ay_q;
      s4_bx_q   <= s3_bx_q;
      s4_by_q   <= s3_by_q;
      s4_cx_q   <= s3_cx_q;
      s4_cy_q   <= s3_cy_q;
      s4_d_q    <= s3_d_q;
      s4_negx_q <= s3_negx_q;
      s4_negy_q <= s3_negy_q;
      s4_sel_q  <= s3_sel;
      s4_plx_q  <= s3_magx_q * s3_tu[W-1:0];
      s4_ply_q  <= s3_magy_q * s3_tu[W-1:0];
      s4_phx_q  <= s3_magx_q * s3_tu[2*W:W];
      s4_phy_q  <= s3_magy_q * s3_tu[2*W:W];
    end
  end

  // Stage 5: full dividends.
  logic         s5_vld_q;
  logic [3*W:0] s5_numx_q, s5_numy_q;
  logic [2*W:0] s5_d_q;
  div_side_t    s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_numx_q       <= {s4_phx_q, {W{1'b0}}} + {{(W+1){1'b0}}, s4_plx_q};
      s5_numy_q       <= {s4_phy_q, {W{1'b0}}} + {{(W+1){1'b0}}, s4_ply_q};
      s5_d_q          <= s4_d_q;
      s5_side_q.ax    <= s4_ax_q;
      s5_side_q.ay    <= s4_ay_q;
      s5_side_q.bx    <= s4_bx_q;
      s5_side_q.by    <= s4_by_q;
      s5_side_q.cx    <= s4_cx_q;
      s5_side_q.cy    <= s4_cy_q;
      s5_side_q.neg_x <= s4_negx_q;
      s5_side_q.neg_y <= s4_negy_q;
      s5_side_q.sel   <= s4_sel_q;
    end
  end

  // Projection dividers, one per axis, sharing the squared length.
  pipe_ctl_t    div_ctl;
  logic         divx_vld, divy_vld;
  logic [W-1:0] qx, qy;
  div_side_t    div_side;

  assign div_ctl.en  = en;
  assign div_ctl.vld = s5_vld_q;

  pts_div #(.W(W)) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (s5_numx_q),
    .den_i  (s5_d_q),
    .vld_o  (divx_vld),
    .quo_o  (qx)
  );

  pts_div #(.W(W)) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (s5_numy_q),
    .den_i  (s5_d_q),
    .vld_o  (divy_vld),
    .quo_o  (qy)
  );

  pts_delay #(.Width($bits(div_side_t)), .Depth(W + 1)) u_div_side (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (s5_side_q),
    .data_o (div_side)
  );

  // Stage 6: foot point.
  logic signed [W:0] projx, projy;
  logic [W-1:0]      foot_x, foot_y;
  logic              interior;

  assign projx = div_side.neg_x ? ({div_side.ax[W-1], div_side.ax} - {1'b0, qx})
                                : ({div_side.ax[W-1], div_side.ax} + {1'b0, qx});
  assign projy = div_side.neg_y ? ({div_side.ay[W-1], div_side.ay} - {1'b0, qy})
                                : ({div_side.ay[W-1], div_side.ay} + {1'b0, qy});

  always_comb begin
    case (div_side.sel)
      SEL_A: begin
        foot_x   = div_side.ax;
        foot_y   = div_side.ay;
        interior = 1'b0;
      end
      SEL_B: begin
        foot_x   = div_side.bx;
        foot_y   = div_side.by;
        interior = 1'b0;
      end
      default: begin
        foot_x   = projx[W-1:0];
        foot_y   = projy[W-1:0];
        interior = 1'b1;
      end
    endcase
  end

  logic                s6_vld_q;
  logic signed [W-1:0] s6_fx_q, s6_fy_q, s6_cx_q, s6_cy_q;
  logic signed [W-1:0] s6_ax_q, s6_bx_q;
  logic                s6_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= divx_vld && divy_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_fx_q  <= foot_x;
      s6_fy_q  <= foot_y;
      s6_cx_q  <= div_side.cx;
      s6_cy_q  <= div_side.cy;
      s6_ax_q  <= div_side.ax;
      s6_bx_q  <= div_side.bx;
      s6_int_q <= interior;
    end
  end

  // Stage 7: offset magnitudes from the foot to the point.
  logic signed [W:0] offx, offy;

  assign offx = {s6_cx_q[W-1], s6_cx_q} - {s6_fx_q[W-1], s6_fx_q};
  assign offy = {s6_cy_q[W-1], s6_cy_q} - {s6_fy_q[W-1], s6_fy_q};

  logic       s7_vld_q;
  logic [W:0] s7_mx_q, s7_my_q;
  sqrt_side_t s7_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_mx_q            <= offx[W] ? (W+1)'(-offx) : offx;
      s7_my_q            <= offy[W] ? (W+1)'(-offy) : offy;
      s7_side_q.fx       <= s6_fx_q;
      s7_side_q.fy       <= s6_fy_q;
      s7_side_q.interior <= s6_int_q;
    end
  end

  // Stage 8: squares.
  logic           s8_vld_q;
  logic [2*W+1:0] s8_sx_q, s8_sy_q;
  sqrt_side_t     s8_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else if (en) begin
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_sx_q   <= s7_mx_q * s7_mx_q;
      s8_sy_q   <= s7_my_q * s7_my_q;
      s8_side_q <= s7_side_q;
    end
  end

  // Stage 9: squared distance.
  logic           s9_vld_q;
  logic [2*W+2:0] s9_sq_q;
  sqrt_side_t     s9_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else if (en) begin
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_sq_q   <= {1'b0, s8_sx_q} + {1'b0, s8_sy_q};
      s9_side_q <= s8_side_q;
    end
  end

  // Square root; its last stage is the output register.
  pipe_ctl_t  sqrt_ctl;
  sqrt_side_t out_side;

  assign sqrt_ctl.en  = en;
  assign sqrt_ctl.vld = s9_vld_q;

  pts_sqrt #(.W(W)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sqrt_ctl),
    .rad_i  (s9_sq_q),
    .vld_o  (out_valid_o),
    .root_o (distance_o)
  );

  pts_delay #(.Width($bits(sqrt_side_t)), .Depth(W + 2)) u_sqrt_side (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (s9_side_q),
    .data_o (out_side)
  );

  assign foot_x_o        = out_side.fx;
  assign foot_y_o        = out_side.fy;
  assign interior_foot_o = out_side.interior;

  // A degenerate segment always clamps to its start point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s3_vld_q && s3_d_q == '0) |=> (s4_sel_q == SEL_A))
    else $error("zero-length segment not clamped to start point");

  // A dot product within [0, d] with d non-zero must give a projection.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s3_vld_q && !s3_t_q[2*W+2] && s3_d_q != '0
     && s3_t_q[2*W+1:0] <= {1'b0, s3_d_q}) |=> (s4_sel_q == SEL_PROJ))
    else $error("in-range dot product not treated as projection");

  // A projected foot lies between the segment's end points in x.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s6_vld_q && s6_int_q) |->
      ((s6_ax_q <= s6_bx_q && s6_fx_q >= s6_ax_q && s6_fx_q <= s6_bx_q) ||
       (s6_ax_q > s6_bx_q && s6_fx_q <= s6_ax_q && s6_fx_q >= s6_bx_q)))
    else $error("projected foot outside segment in x");

  // Both dividers run in lock step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    divx_vld == divy_vld)
    else $error("divider valid bits out of step");

endmodule

[tb/tb_top.sv]
// Testbench for the point to segment distance pipeline.
`timescale 1ns / 100ps

module tb_top;
  localparam int CW = 24;
  localparam int LATENCY = 2 * CW + 12;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_RANDOM = 530;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  } query_t;

  typedef struct packed {
    logic signed [CW-1:0] fx, fy;
    logic [CW:0] len;
    logic interior;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] seg_start_x_i = '0, seg_start_y_i = '0;
  logic signed [CW-1:0] seg_end_x_i = '0, seg_end_y_i = '0;
  logic signed [CW-1:0] point_x_i = '0, point_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CW-1:0] foot_x_o, foot_y_o;
  logic [CW:0] distance_o;
  logic interior_foot_o;

  point_to_segment_distance_top #(.COORD_WIDTH(CW)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .seg_start_x_i, .seg_start_y_i, .seg_end_x_i, .seg_end_y_i,
    .point_x_i, .point_y_i,
    .out_valid_o, .out_ready_i,
    .foot_x_o, .foot_y_o, .distance_o, .interior_foot_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  query_t  pending_queries[$];
  answer_t expected_answers[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  function automatic longint isqrt(longint n);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // Offset along one axis: |ab|*t/d rounded half up on the magnitude.
  function automatic longint proj_offset(longint ab, longint t, longint d);
    logic [127:0] num, q, r;
    num = 128'(ab < 0 ? -ab : ab) * 128'(t);
    q = num / 128'(d);
    r = num % 128'(d);
    if (r >= 128'(d) - r) q = q + 1;
    return ab < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic answer_t nearest_foot(query_t q);
    longint ax, ay, bx, by, cx, cy, abx, aby, t, d, fx, fy, dx, dy;
    answer_t a;
    ax = q.ax; ay = q.ay; bx = q.bx; by = q.by; cx = q.cx; cy = q.cy;
    abx = bx - ax; aby = by - ay;
    t = abx * (cx - ax) + aby * (cy - ay);
    d = abx * abx + aby * aby;
    a.interior = 1'b0;
    if (t < 0 || d == 0) begin
      fx = ax; fy = ay;
    end else if (t > d) begin
      fx = bx; fy = by;
    end else begin
      fx = ax + proj_offset(abx, t, d);
      fy = ay + proj_offset(aby, t, d);
      a.interior = 1'b1;
    end
    dx = cx - fx; dy = cy - fy;
    a.fx = fx[CW-1:0];
    a.fy = fy[CW-1:0];
    a.len = (CW+1)'(isqrt(dx * dx + dy * dy));
    return a;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(int span);
    if (span == 0) return CW'($urandom);
    return CW'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic query_t make_query(logic signed [CW-1:0] ax, ay, bx, by, cx, cy);
    query_t q;
    q.ax = ax; q.ay = ay; q.bx = bx; q.by = by; q.cx = cx; q.cy = cy;
    return q;
  endfunction

  // Driver: offers the next pending query, idling at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          query_t q;
          q = pending_queries.pop_front();
          in_valid_i <= 1'b1;
          {seg_start_x_i, seg_start_y_i, seg_end_x_i, seg_end_y_i, point_x_i, point_y_i}
            <= q;
          expected_answers.push_back(nearest_foot(q));
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_answers.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (foot_x_o !== e.fx) begin
            $error("foot_x expected %0d got %0d", e.fx, foot_x_o); errors++;
          end
          if (foot_y_o !== e.fy) begin
            $error("foot_y expected %0d got %0d", e.fy, foot_y_o); errors++;
          end
          if (distance_o !== e.len) begin
            $error("distance expected %0d got %0d", e.len, distance_o); errors++;
          end
          if (interior_foot_o !== e.interior) begin
            $error("interior_foot expected %0d got %0d", e.interior, interior_foot_o);
            errors++;
          end
        end
      end
      out_ready_i <= !recv_hold && $urandom_range(99) >= recv_stall_pct;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Expectations are pushed on offer, so this waits for the offer to be taken too.
  task automatic wait_drained();
    while (pending_queries.size() != 0 || expected_answers.size() != 0 ||
           (in_valid_i && !in_ready_o))
      @(posedge clk_i);
  endtask

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, clamping both ways, ends of the projection, degenerate segment.
    pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0));
    pending_queries.push_back(make_query(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX));
    pending_queries.push_back(make_query(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN));
    pending_queries.push_back(make_query(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX));
    pending_queries.push_back(make_query(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN));
    pending_queries.push_back(make_query(0, 0, 256, 0, -512, 300));
    pending_queries.push_back(make_query(0, 0, 256, 0, 1024, -300));
    pending_queries.push_back(make_query(0, 0, 256, 0, 0, 700));
    pending_queries.push_back(make_query(0, 0, 256, 0, 256, -700));
    pending_queries.push_back(make_query(0, 0, 3, 0, 1, 5));
    pending_queries.push_back(make_query(0, 0, -3, 0, -2, 5));
    pending_queries.push_back(make_query(0, 0, 2, 0, 1, 9));
    pending_queries.push_back(make_query(0, 0, -2, 0, -1, 9));
    pending_queries.push_back(make_query(0, 0, 3, 7, 5, 1));
    pending_queries.push_back(make_query(100, -100, 100, -100, 5, 5));
    pending_queries.push_back(make_query(CMAX, 0, CMIN, 0, 0, CMAX));
    pending_queries.push_back(make_query(0, CMIN, 0, CMAX, CMIN, 0));
    pending_queries.push_back(make_query(-1, -1, -1, -1, -1, -1));
    pending_queries.push_back(make_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    wait_drained();

    // Receiver holds off for a long stretch while the sender keeps offering.
    recv_hold = 1'b1;
    for (int i = 0; i < 120; i++)
      pending_queries.push_back(make_query(rand_coord(0), rand_coord(0), rand_coord(0),
        rand_coord(0), rand_coord(0), rand_coord(0)));
    repeat (300) @(posedge clk_i);
    recv_hold = 1'b0;
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 53 : 21) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 53 : 21) : 0;
      for (int i = 0; i < (NUM_RANDOM - 120) / 4; i++) begin
        int span;
        case ($urandom_range(3))
          0: span = 0;
          1: span = 1000;
          2: span = 20;
          default: span = 1 << $urandom_range(4, CW - 2);
        endcase
        pending_queries.push_back(make_query(rand_coord(span), rand_coord(span),
          rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)));
        if ($urandom_range(15) == 0) begin
          query_t q;
          q = pending_queries.pop_back();
          q.bx = q.ax; q.by = q.ay;
          pending_queries.push_back(q);
        end
      end
      wait_drained();
    end

    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
